### design/secded_hamming_stream_encoder_top_assert.svh
// assertion macros shared by the encoder modules
// each macro expects i_clk and i_rst_n in the enclosing module
`ifndef SECDED_HAMMING_STREAM_ENCODER_TOP_ASSERT_SVH
`define SECDED_HAMMING_STREAM_ENCODER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define SHSE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("shse assertion failed");

// consequent holds in the cycle after the antecedent
`define SHSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shse assertion failed");

`endif

### design/shse_pkg.sv
package shse_pkg;

    localparam int DATA_BITS_DEF = 57;
    localparam int CODE_BITS_DEF = 64;
    localparam int MAX_CODE_BITS = 64;
    localparam int MAX_OUT       = 8;
    localparam int BYTE_W        = 8;
    localparam int LEFT_W        = $clog2(MAX_OUT + 1);
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd;

    // what the back end has to do with one queued job
    typedef struct packed {
        logic flush;
        logic has_block;
    } t_job_ctl;

    function automatic logic is_pow2(int pos);
        return (pos & (pos - 1)) == 0;
    endfunction

    // data slot held by a non-power-of-two codeword position (1-indexed)
    function automatic int slot_of(int pos);
        int lg;
        lg = 0;
        for (int k = 0; k < 8; k++) begin
            if ((1 << k) <= pos) lg = k;
        end
        return pos - 2 - lg;
    endfunction

    // data positions covered by parity bit k
    function automatic logic [MAX_CODE_BITS-1:0] par_mask(int code_bits, int k);
        logic [MAX_CODE_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            m[i] = ((i + 1) < code_bits) && (((i + 1) >> k) & 1) != 0 && !is_pow2(i + 1);
        end
        return m;
    endfunction

    // bits left in the byte accumulator once a job is done
    function automatic logic [2:0] leftover(logic [2:0] b, logic blk, logic flush,
                                            int code_bits);
        int total;
        int full;
        total = int'(b) + (blk ? code_bits : 0);
        full  = total >> 3;
        if (flush && (total & 7) != 0 && full < MAX_OUT) return 3'd0;
        return 3'(total & 7);
    endfunction

    // beats caused by a job
    function automatic logic [LEFT_W-1:0] job_bytes(logic [2:0] b, logic blk, logic flush,
                                                    int code_bits);
        int total;
        int full;
        int part;
        total = int'(b) + (blk ? code_bits : 0);
        full  = total >> 3;
        part  = (flush && (total & 7) != 0 && full < MAX_OUT) ? 1 : 0;
        return LEFT_W'(full + part);
    endfunction

endpackage

### design/shse_if.sv
interface shse_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface shse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### design/secded_hamming_stream_encoder_top.sv
// path: the filling byte passes the job queue, the back-end load and the output register before its beat
// throughput: one input beat per cycle while the two-entry job queue has room
// output: one beat per cycle while o_out.ready holds, with a load step between jobs, set by the byte serialiser
// a full block gives CODE_BITS/8 beats, so the serialiser bounds the sustained input rate
// reset: synchronous active-low i_rst_n empties the queue and clears all bit and byte state but r_ob and r_ol
module secded_hamming_stream_encoder_top import shse_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    shse_in_if.sink     i_in,
    shse_out_if.source  o_out
);

    // front to queue
    logic                 w_push;
    t_job_ctl             w_ctl;
    logic [DATA_BITS-1:0] w_data;
    logic                 w_full;

    // queue to back
    logic                 w_q_valid;
    t_job_ctl             w_q_ctl;
    logic [DATA_BITS-1:0] w_q_data;
    logic                 w_pop;

    // front: packs incoming bits msb first, tracks the output bit phase so it
    // knows whether a flush produces any beat, and queues a job per full
    // block or productive flush
    shse_front #(
        .DATA_BITS (DATA_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (w_push),
        .o_ctl   (w_ctl),
        .o_data  (w_data),
        .i_full  (w_full)
    );

    // short job queue, lets the front keep taking bytes while beats drain
    shse_queue #(
        .DATA_BITS (DATA_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ctl   (w_ctl),
        .i_data  (w_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_ctl   (w_q_ctl),
        .o_data  (w_q_data)
    );

    // back: encodes the block on load, merges it behind the partial byte and
    // serialises beats lsb first through a registered output stage
    shse_back #(
        .DATA_BITS (DATA_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_ctl   (w_q_ctl),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule

### design/shse_queue.sv
`include "secded_hamming_stream_encoder_top_assert.svh"

module shse_queue import shse_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_job_ctl             i_ctl,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output t_job_ctl             o_ctl,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job_ctl             r_ctl  [QUEUE_DEPTH];
    logic [DATA_BITS-1:0] r_data [QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0]     r_count, n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wp]  <= i_ctl;
            r_data[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_ctl   = r_ctl[r_rp];
    assign o_data  = r_data[r_rp];

    `SHSE_ASSERT_ALWAYS(a_no_overflow, !(i_push && r_count == CNT_W'(QUEUE_DEPTH)))
    `SHSE_ASSERT_ALWAYS(a_no_underflow, !(i_pop && r_count == '0))

endmodule

### design/shse_front.sv
`include "secded_hamming_stream_encoder_top_assert.svh"

module shse_front import shse_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    shse_in_if.sink              i_in,
    output logic                 o_push,
    output t_job_ctl             o_ctl,
    output logic [DATA_BITS-1:0] o_data,
    input  logic                 i_full
);

    localparam int PCNT_W = $clog2(DATA_BITS);
    localparam int SUM_W  = $clog2(DATA_BITS + BYTE_W);
    localparam int EXT_W  = DATA_BITS + BYTE_W;

    logic [DATA_BITS-1:0] r_pend, n_pend;
    logic [PCNT_W-1:0]    r_pcnt, n_pcnt;
    logic [2:0]           r_bcnt, n_bcnt;

    logic                 w_accept;
    logic [BYTE_W-1:0]    w_rev;
    logic [EXT_W-1:0]     w_ext;
    logic [SUM_W-1:0]     w_sum;
    logic                 w_fill;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    // first arriving bit is the byte msb
    always_comb begin
        for (int j = 0; j < BYTE_W; j++) begin
            w_rev[j] = i_in.data_byte[BYTE_W-1-j];
        end
    end

    assign w_ext  = EXT_W'(r_pend) | (EXT_W'(w_rev) << r_pcnt);
    assign w_sum  = SUM_W'(r_pcnt) + SUM_W'(BYTE_W);
    assign w_fill = (w_sum >= SUM_W'(DATA_BITS));

    always_comb begin
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        n_bcnt = r_bcnt;
        o_push = 1'b0;
        o_ctl  = '0;
        o_data = w_ext[DATA_BITS-1:0];
        if (w_accept) begin
            case (t_cmd'(i_in.cmd))
                CMD_APPEND: begin
                    if (w_fill) begin
                        o_push        = 1'b1;
                        o_ctl.has_block = 1'b1;
                        n_pend = DATA_BITS'(w_ext[EXT_W-1:DATA_BITS]);
                        n_pcnt = PCNT_W'(w_sum - SUM_W'(DATA_BITS));
                        n_bcnt = leftover(r_bcnt, 1'b1, 1'b0, CODE_BITS);
                    end else begin
                        n_pend = w_ext[DATA_BITS-1:0];
                        n_pcnt = PCNT_W'(w_sum);
                    end
                end
                CMD_FLUSH: begin
                    o_data = r_pend;
                    if (r_pcnt != '0) begin
                        o_push          = 1'b1;
                        o_ctl.has_block = 1'b1;
                        o_ctl.flush     = 1'b1;
                        n_bcnt = leftover(r_bcnt, 1'b1, 1'b1, CODE_BITS);
                    end else if (r_bcnt != '0) begin
                        o_push      = 1'b1;
                        o_ctl.flush = 1'b1;
                        n_bcnt = leftover(r_bcnt, 1'b0, 1'b1, CODE_BITS);
                    end
                    n_pend = '0;
                    n_pcnt = '0;
                end
                default: begin
                    n_pend = r_pend;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= '0;
            r_bcnt <= '0;
        end else begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
            r_bcnt <= n_bcnt;
        end
    end

    `SHSE_ASSERT_NEXT(a_flush_clears, w_accept && i_in.cmd == CMD_FLUSH, r_pcnt == '0)

endmodule

### design/shse_back.sv
`include "secded_hamming_stream_encoder_top_assert.svh"

module shse_back import shse_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int CODE_BITS = CODE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_job_ctl             i_q_ctl,
    input  logic [DATA_BITS-1:0] i_q_data,
    output logic                 o_q_pop,
    shse_out_if.source           o_out
);

    localparam int BUF_W = CODE_BITS + 7;
    localparam int CNT_W = $clog2(CODE_BITS + 8);
    localparam int NPAR  = $clog2(CODE_BITS);

    logic [BUF_W-1:0]  r_buf, n_buf;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_ov, n_ov;
    logic [BYTE_W-1:0] r_ob, n_ob;
    logic              r_ol, n_ol;

    logic [CODE_BITS-1:0] w_placed;
    logic [CODE_BITS-2:0] w_body;
    logic [CODE_BITS-1:0] w_code;
    logic [NPAR-1:0]      w_par;
    logic [BUF_W-1:0]     w_shifted;
    logic                 w_load;
    logic                 w_step;

    // data bits into non-power-of-two positions, spare slots zero
    for (genvar gi = 0; gi < CODE_BITS; gi++) begin : g_place
        if (gi + 1 < CODE_BITS && !is_pow2(gi + 1) && slot_of(gi + 1) < DATA_BITS) begin : g_data
            assign w_placed[gi] = i_q_data[slot_of(gi + 1)];
        end else begin : g_zero
            assign w_placed[gi] = 1'b0;
        end
    end

    for (genvar gk = 0; gk < NPAR; gk++) begin : g_par
        localparam logic [CODE_BITS-1:0] MASK = CODE_BITS'(par_mask(CODE_BITS, gk));
        assign w_par[gk] = ^(w_placed & MASK);
    end

    always_comb begin
        w_body = w_placed[CODE_BITS-2:0];
        for (int k = 0; k < NPAR; k++) begin
            w_body[(1 << k) - 1] = w_par[k];
        end
    end

    assign w_code    = {^w_body, w_body};
    assign w_shifted = i_q_ctl.has_block ? (BUF_W'(w_code) << r_cnt[2:0]) : '0;

    assign w_load  = (r_left == '0) && i_q_valid;
    assign w_step  = (r_left != '0) && (!r_ov || o_out.ready);
    assign o_q_pop = w_load;

    always_comb begin
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_left = r_left;
        if (w_load) begin
            n_buf  = r_buf | w_shifted;
            n_cnt  = r_cnt + (i_q_ctl.has_block ? CNT_W'(CODE_BITS) : '0);
            n_left = job_bytes(r_cnt[2:0], i_q_ctl.has_block, i_q_ctl.flush, CODE_BITS);
        end else if (w_step) begin
            n_buf  = r_buf >> BYTE_W;
            n_cnt  = (r_cnt >= CNT_W'(BYTE_W)) ? r_cnt - CNT_W'(BYTE_W) : '0;
            n_left = r_left - 1'b1;
        end
    end

    always_comb begin
        n_ov = r_ov;
        n_ob = r_ob;
        n_ol = r_ol;
        if (w_step) begin
            n_ov = 1'b1;
            n_ob = r_buf[BYTE_W-1:0];
            n_ol = (r_left == LEFT_W'(1));
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_cnt  <= '0;
            r_left <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_left <= n_left;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ob <= n_ob;
        r_ol <= n_ol;
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last     = r_ol;

    `SHSE_ASSERT_NEXT(a_load_gives_beats, w_load, r_left != '0)
    `SHSE_ASSERT_NEXT(a_last_ends_job, w_step && r_left == LEFT_W'(1), r_left == '0)
    `SHSE_ASSERT_ALWAYS(a_idle_part_byte, r_left != '0 || r_cnt < CNT_W'(BYTE_W))

endmodule
